// ===== rtl/face_flux_momentum_interpolation_macros.svh =====
// Assertion macros for the face flux interpolation RTL.
// Included by face_flux_momentum_interpolation.sv; no other dependencies.
`ifndef FACE_FLUX_MOMENTUM_INTERPOLATION_MACROS_SVH
`define FACE_FLUX_MOMENTUM_INTERPOLATION_MACROS_SVH
`ifndef SYNTHESIS
`define FFMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`define FFMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`else
`define FFMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define FFMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ffmi_pkg.sv =====
// Shared types, constants and fixed-point helpers for the face flux pipeline.
// No dependencies.
package ffmi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int DIV_STEPS  = WORD_BITS - 1;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int MATH_LAT   = 7;
    localparam int PIPE_LAT   = DIV_LAT + MATH_LAT;

    localparam logic signed [WORD_BITS-1:0] Q_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] Q_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS+1:0] ONE_Q = (WORD_BITS+2)'(1) << FRAC_BITS;
    localparam logic [30:0] DENSITY_RESET = 31'd65536;

    typedef struct packed {
        logic [30:0]        offset_to_face;
        logic [30:0]        center_spacing;
        logic [30:0]        extent_first;
        logic [30:0]        extent_second;
        logic signed [31:0] vel_here;
        logic signed [31:0] vel_next;
        logic signed [31:0] invdiag_here;
        logic signed [31:0] invdiag_next;
        logic signed [31:0] grad_here;
        logic signed [31:0] grad_next;
        logic signed [31:0] press_here;
        logic signed [31:0] press_next;
    } t_in;

    typedef struct packed {
        logic signed [31:0] face_flux;
        logic signed [31:0] link_coef;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] val;
        logic                        flag;
    } t_res;

    function automatic logic signed [WORD_BITS+1:0] sx(input logic signed [WORD_BITS-1:0] x);
        return {{2{x[WORD_BITS-1]}}, x};
    endfunction

    function automatic t_res sat_w(input logic signed [WORD_BITS+1:0] x);
        t_res r;
        if (x > sx(Q_MAX)) begin
            r.val = Q_MAX; r.flag = 1'b1;
        end else if (x < sx(Q_MIN)) begin
            r.val = Q_MIN; r.flag = 1'b1;
        end else begin
            r.val = x[WORD_BITS-1:0]; r.flag = 1'b0;
        end
        return r;
    endfunction

    // Multiply magnitudes, truncate toward zero, clip to the word.
    function automatic t_res qmul(input logic signed [WORD_BITS-1:0] a,
                                  input logic signed [WORD_BITS-1:0] b);
        logic [WORD_BITS-1:0]             ua;
        logic [WORD_BITS-1:0]             ub;
        logic [2*WORD_BITS-1:0]           p;
        logic [2*WORD_BITS-FRAC_BITS-1:0] m;
        logic                             neg;
        t_res                             r;
        ua  = a[WORD_BITS-1] ? (WORD_BITS'(0) - $unsigned(a)) : $unsigned(a);
        ub  = b[WORD_BITS-1] ? (WORD_BITS'(0) - $unsigned(b)) : $unsigned(b);
        p   = (2*WORD_BITS)'(ua) * (2*WORD_BITS)'(ub);
        m   = p[2*WORD_BITS-1:FRAC_BITS];
        neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        if (neg) begin
            if (m > (2*WORD_BITS-FRAC_BITS)'($unsigned(Q_MAX)) + 1'b1) begin
                r.val = Q_MIN; r.flag = 1'b1;
            end else begin
                r.val = WORD_BITS'((2*WORD_BITS-FRAC_BITS)'(0) - m); r.flag = 1'b0;
            end
        end else begin
            if (m > (2*WORD_BITS-FRAC_BITS)'($unsigned(Q_MAX))) begin
                r.val = Q_MAX; r.flag = 1'b1;
            end else begin
                r.val = m[WORD_BITS-1:0]; r.flag = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/ffmi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, Q16.16 result.
// Depends on ffmi_pkg.
module ffmi_div (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [ffmi_pkg::WORD_BITS-1:0]        i_num,
    input  logic                                  i_neg,
    input  logic [ffmi_pkg::WORD_BITS-2:0]        i_den,
    output logic signed [ffmi_pkg::WORD_BITS-1:0] o_quo,
    output logic                                  o_sat
);
    localparam int W = ffmi_pkg::WORD_BITS;
    localparam int N = ffmi_pkg::DIV_STEPS;

    logic [W-2:0] r_rem  [0:N];
    logic [W-2:0] r_low  [0:N];
    logic [W-2:0] r_q    [0:N];
    logic [W-2:0] r_den  [0:N];
    logic         r_neg  [0:N];
    logic         r_zero [0:N];
    logic         r_ovf  [0:N];

    // Prepare: numerator is i_num << FRAC_BITS; overflow if quotient needs the sign bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (W-1)'(i_num >> (W - 1 - ffmi_pkg::FRAC_BITS));
            r_low[0]  <= (W-1)'({i_num, {ffmi_pkg::FRAC_BITS{1'b0}}});
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_zero[0] <= (i_num == '0);
            r_ovf[0]  <= ((2*W)'(i_num) >= ((2*W)'(i_den) << (W - 1 - ffmi_pkg::FRAC_BITS)));
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [W-1:0] n_trial;
        logic         n_take;
        assign n_trial = {r_rem[k-1], r_low[k-1][W-2]};
        assign n_take  = (n_trial >= W'(r_den[k-1]));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_take ? (W-1)'(n_trial - W'(r_den[k-1])) : n_trial[W-2:0];
                r_low[k]  <= r_low[k-1] << 1;
                r_q[k]    <= {r_q[k-1][W-3:0], n_take};
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                r_ovf[k]  <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        if (r_zero[N]) begin
            o_quo = '0; o_sat = 1'b0;
        end else if (r_ovf[N]) begin
            o_quo = r_neg[N] ? ffmi_pkg::Q_MIN : ffmi_pkg::Q_MAX;
            o_sat = 1'b1;
        end else begin
            o_quo = r_neg[N] ? -$signed({1'b0, r_q[N]}) : $signed({1'b0, r_q[N]});
            o_sat = 1'b0;
        end
    end
endmodule

// ===== rtl/face_flux_momentum_interpolation.sv =====
// Top level: face mass flux with momentum interpolation, fixed-point pipeline.
// Depends on ffmi_pkg, ffmi_div and the assertion macro header.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | i_in_valid, i_in_data, o_in_stall    | face in
//  output  | o_out_valid, o_out_data, i_out_stall | result out
//  config  | i_cfg_valid, i_cfg_data, o_cfg_ready | density write
//
// One face per cycle while the output is not stalled (32 divider stages, 7 arithmetic stages).
// The two divisions by center spacing set the depth: one quotient bit per stage.
// Synchronous active-low reset clears all valid bits and sets density to 1.0.
// A stalled result freezes the whole pipeline; o_in_stall follows it.
`include "face_flux_momentum_interpolation_macros.svh"
module face_flux_momentum_interpolation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ffmi_pkg::t_in    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output ffmi_pkg::t_out   o_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic [30:0]      i_cfg_data,
    output logic             o_cfg_ready
);
    localparam int W  = ffmi_pkg::WORD_BITS;
    localparam int DL = ffmi_pkg::DIV_LAT;
    localparam int PL = ffmi_pkg::PIPE_LAT;

    typedef struct packed {
        logic [30:0]        spc;
        logic [30:0]        ext1;
        logic [30:0]        ext2;
        logic signed [31:0] vh;
        logic signed [31:0] vn;
        logic signed [31:0] ih;
        logic signed [31:0] inx;
        logic signed [31:0] gh;
        logic signed [31:0] gn;
    } t_carry;

    logic [30:0]    r_density;
    logic [PL-1:0]  r_vld;
    t_carry         r_dly [0:DL-1];
    logic           adv;
    logic           in_acc;

    // divider hookup
    logic signed [W:0]   n_pdiff;
    logic [W:0]          n_pmag;
    logic signed [W-1:0] fe_q;
    logic                fe_sat;
    logic signed [W-1:0] gf_q;
    logic                gf_sat;

    assign adv         = !(r_vld[PL-1] && i_out_stall);
    assign o_in_stall  = !adv;
    assign in_acc      = i_in_valid && adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= ffmi_pkg::DENSITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_density <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PL-2:0], in_acc};
        end
    end

    assign n_pdiff = {i_in_data.press_next[31], i_in_data.press_next}
                   - {i_in_data.press_here[31], i_in_data.press_here};
    assign n_pmag  = n_pdiff[W] ? ((W+1)'(0) - $unsigned(n_pdiff)) : $unsigned(n_pdiff);

    ffmi_div u_div_fe (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ({1'b0, i_in_data.offset_to_face}),
        .i_neg (1'b0),
        .i_den (i_in_data.center_spacing),
        .o_quo (fe_q),
        .o_sat (fe_sat)
    );

    ffmi_div u_div_gf (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (n_pmag[W-1:0]),
        .i_neg (n_pdiff[W]),
        .i_den (i_in_data.center_spacing),
        .o_quo (gf_q),
        .o_sat (gf_sat)
    );

    // Carry the remaining fields alongside the divider.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly[0] <= '{spc: i_in_data.center_spacing, ext1: i_in_data.extent_first,
                          ext2: i_in_data.extent_second, vh: i_in_data.vel_here,
                          vn: i_in_data.vel_next, ih: i_in_data.invdiag_here,
                          inx: i_in_data.invdiag_next, gh: i_in_data.grad_here,
                          gn: i_in_data.grad_next};
            for (int k = 1; k < DL; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // Stage E1: fp, area, gradient mean
    logic signed [W-1:0] r1_fe, r1_fp, r1_area, r1_gm, r1_gf, r1_spc;
    logic signed [W-1:0] r1_vh, r1_vn, r1_ih, r1_inx;
    logic                r1_f;
    ffmi_pkg::t_res      n1_fp, n1_area;
    logic signed [W:0]   n1_gsum;
    logic signed [W:0]   n1_gm;
    t_carry              c31;

    assign c31     = r_dly[DL-1];
    assign n1_fp   = ffmi_pkg::sat_w(ffmi_pkg::ONE_Q - ffmi_pkg::sx(fe_q));
    assign n1_area = ffmi_pkg::qmul({1'b0, c31.ext1}, {1'b0, c31.ext2});
    assign n1_gsum = {c31.gh[31], c31.gh} + {c31.gn[31], c31.gn};
    // halve toward zero
    assign n1_gm   = (n1_gsum + (W+1)'(n1_gsum[W])) >>> 1;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_fe   <= fe_q;
            r1_fp   <= n1_fp.val;
            r1_area <= n1_area.val;
            r1_gm   <= n1_gm[W-1:0];
            r1_gf   <= gf_q;
            r1_spc  <= {1'b0, c31.spc};
            r1_vh   <= c31.vh;
            r1_vn   <= c31.vn;
            r1_ih   <= c31.ih;
            r1_inx  <= c31.inx;
            r1_f    <= fe_sat | gf_sat | n1_fp.flag | n1_area.flag;
        end
    end

    // Stage E2: weighted products, volume, density times area, gradient difference
    logic signed [W-1:0] r2_m1, r2_m2, r2_m3, r2_m4, r2_vol, r2_d, r2_gg, r2_area;
    logic                r2_f;
    ffmi_pkg::t_res      n2_m1, n2_m2, n2_m3, n2_m4, n2_vol, n2_d, n2_gg;

    assign n2_m1  = ffmi_pkg::qmul(r1_fp, r1_vh);
    assign n2_m2  = ffmi_pkg::qmul(r1_fe, r1_vn);
    assign n2_m3  = ffmi_pkg::qmul(r1_fp, r1_ih);
    assign n2_m4  = ffmi_pkg::qmul(r1_fe, r1_inx);
    assign n2_vol = ffmi_pkg::qmul(r1_spc, r1_area);
    assign n2_d   = ffmi_pkg::qmul({1'b0, r_density}, r1_area);
    assign n2_gg  = ffmi_pkg::sat_w(ffmi_pkg::sx(r1_gf) - ffmi_pkg::sx(r1_gm));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_m1   <= n2_m1.val;
            r2_m2   <= n2_m2.val;
            r2_m3   <= n2_m3.val;
            r2_m4   <= n2_m4.val;
            r2_vol  <= n2_vol.val;
            r2_d    <= n2_d.val;
            r2_gg   <= n2_gg.val;
            r2_area <= r1_area;
            r2_f    <= r1_f | n2_m1.flag | n2_m2.flag | n2_m3.flag | n2_m4.flag
                     | n2_vol.flag | n2_d.flag | n2_gg.flag;
        end
    end

    // Stage E3: face velocity and face inverse diagonal
    logic signed [W-1:0] r3_uf, r3_af, r3_vol, r3_d, r3_gg, r3_area;
    logic                r3_f;
    ffmi_pkg::t_res      n3_uf, n3_af;

    assign n3_uf = ffmi_pkg::sat_w(ffmi_pkg::sx(r2_m1) + ffmi_pkg::sx(r2_m2));
    assign n3_af = ffmi_pkg::sat_w(ffmi_pkg::sx(r2_m3) + ffmi_pkg::sx(r2_m4));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_uf   <= n3_uf.val;
            r3_af   <= n3_af.val;
            r3_vol  <= r2_vol;
            r3_d    <= r2_d;
            r3_gg   <= r2_gg;
            r3_area <= r2_area;
            r3_f    <= r2_f | n3_uf.flag | n3_af.flag;
        end
    end

    // Stage E4
    logic signed [W-1:0] r4_c1, r4_l1, r4_uf, r4_gg, r4_area, r4_d;
    logic                r4_f;
    ffmi_pkg::t_res      n4_c1, n4_l1;

    assign n4_c1 = ffmi_pkg::qmul(r3_af, r3_vol);
    assign n4_l1 = ffmi_pkg::qmul(r3_d, r3_af);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_c1   <= n4_c1.val;
            r4_l1   <= n4_l1.val;
            r4_uf   <= r3_uf;
            r4_gg   <= r3_gg;
            r4_area <= r3_area;
            r4_d    <= r3_d;
            r4_f    <= r3_f | n4_c1.flag | n4_l1.flag;
        end
    end

    // Stage E5
    logic signed [W-1:0] r5_corr, r5_l2, r5_uf, r5_d;
    logic                r5_f;
    ffmi_pkg::t_res      n5_corr, n5_l2;

    assign n5_corr = ffmi_pkg::qmul(r4_c1, r4_gg);
    assign n5_l2   = ffmi_pkg::qmul(r4_l1, r4_area);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_corr <= n5_corr.val;
            r5_l2   <= n5_l2.val;
            r5_uf   <= r4_uf;
            r5_d    <= r4_d;
            r5_f    <= r4_f | n5_corr.flag | n5_l2.flag;
        end
    end

    // Stage E6
    logic signed [W-1:0] r6_t, r6_link, r6_d;
    logic                r6_f;
    ffmi_pkg::t_res      n6_t, n6_link;

    assign n6_t    = ffmi_pkg::sat_w(ffmi_pkg::sx(r5_uf) - ffmi_pkg::sx(r5_corr));
    assign n6_link = ffmi_pkg::sat_w((W+2)'(0) - ffmi_pkg::sx(r5_l2));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_t    <= n6_t.val;
            r6_link <= n6_link.val;
            r6_d    <= r5_d;
            r6_f    <= r5_f | n6_t.flag | n6_link.flag;
        end
    end

    // Stage E7: output register
    ffmi_pkg::t_out r_out;
    ffmi_pkg::t_res n7_flux;

    assign n7_flux = ffmi_pkg::qmul(r6_d, r6_t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.face_flux <= n7_flux.val;
            r_out.link_coef <= r6_link;
            r_out.saturated <= r6_f | n7_flux.flag;
        end
    end

    assign o_out_valid = r_vld[PL-1];
    assign o_out_data  = r_out;

    `FFMI_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg_valid, r_density == $past(i_cfg_data))
    `FFMI_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(r_vld))
    `FFMI_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_vld[PL-1])
endmodule

// ===== test/face_flux_momentum_interpolation_test.sv =====
// Testbench for face_flux_momentum_interpolation: drives face transactions with random
// idling, predicts flux and link coefficient in fixed point, checks results in order.
// Depends on ffmi_pkg and the face_flux_momentum_interpolation RTL.
`timescale 1ns / 1ps
module face_flux_momentum_interpolation_test;

    localparam int LATENCY    = ffmi_pkg::PIPE_LAT + 4;
    localparam int STALL_LIMIT = 20000;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    ffmi_pkg::t_in  in_data = '0;
    logic   in_stall;
    logic   out_valid;
    ffmi_pkg::t_out out_data;
    logic   out_stall = 1'b0;
    logic   cfg_valid = 1'b0;
    logic [30:0] cfg_data = '0;
    logic   cfg_ready;

    face_flux_momentum_interpolation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #10 i_clk = ~i_clk;

    ffmi_pkg::t_in  face_queue[$];
    ffmi_pkg::t_out expected_results[$];
    logic [30:0] density_q = ffmi_pkg::DENSITY_RESET;
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;
    bit     hold_output = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;
    logic   in_stall_seen = 1'b1;

    function automatic longint clip(longint x, inout bit f);
        if (x > WMAX) begin
            f = 1'b1;
            return WMAX;
        end
        if (x < WMIN) begin
            f = 1'b1;
            return WMIN;
        end
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b, inout bit f);
        logic [127:0] p;
        logic [127:0] m;
        bit neg;
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = p >> ffmi_pkg::FRAC_BITS;
        neg = (a < 0) != (b < 0);
        if (neg && m > 128'(WMAX) + 1) begin
            f = 1'b1;
            return WMIN;
        end
        if (!neg && m > 128'(WMAX)) begin
            f = 1'b1;
            return WMAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_div(longint num, longint den, inout bit f);
        longint un;
        longint q;
        longint r;
        longint v;
        un = num < 0 ? -num : num;
        if (un == 0) return 0;
        if (den == 0) begin
            f = 1'b1;
            return num < 0 ? WMIN : WMAX;
        end
        q = un / den;
        r = un % den;
        if (q > (WMAX >>> ffmi_pkg::FRAC_BITS)) begin
            f = 1'b1;
            return num < 0 ? WMIN : WMAX;
        end
        v = (q << ffmi_pkg::FRAC_BITS) + ((r << ffmi_pkg::FRAC_BITS) / den);
        return clip(num < 0 ? -v : v, f);
    endfunction

    function automatic ffmi_pkg::t_out face_flux_of(ffmi_pkg::t_in x, logic [30:0] rho_bits);
        bit f;
        longint spc, rho, fe, fp, area, vol, d, gmean, uface, aface, gface, corr;
        ffmi_pkg::t_out r;
        f = 1'b0;
        spc = longint'(x.center_spacing);
        rho = longint'(rho_bits);
        fe = fx_div(longint'(x.offset_to_face), spc, f);
        fp = clip(ONE - fe, f);
        area = fx_mul(longint'(x.extent_first), longint'(x.extent_second), f);
        vol = fx_mul(spc, area, f);
        d = fx_mul(rho, area, f);
        gmean = clip((longint'(x.grad_here) + longint'(x.grad_next)) / 2, f);
        uface = clip(fx_mul(fp, x.vel_here, f) + fx_mul(fe, x.vel_next, f), f);
        aface = clip(fx_mul(fp, x.invdiag_here, f) + fx_mul(fe, x.invdiag_next, f), f);
        gface = fx_div(longint'(x.press_next) - longint'(x.press_here), spc, f);
        corr = fx_mul(fx_mul(aface, vol, f), clip(gface - gmean, f), f);
        r.face_flux = 32'(fx_mul(d, clip(uface - corr, f), f));
        r.link_coef = 32'(clip(-fx_mul(fx_mul(d, aface, f), area, f), f));
        r.saturated = f;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 255)) << $urandom_range(8, 20);
            1: return -(32'($urandom_range(0, 255)) << $urandom_range(8, 20));
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    function automatic ffmi_pkg::t_in random_face();
        ffmi_pkg::t_in x;
        x.center_spacing = 31'($urandom_range(1, 3) << $urandom_range(12, 18))
                           + 31'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) x.center_spacing = 31'($urandom()) | 31'd1;
        x.offset_to_face = 31'(($urandom_range(0, 100) * longint'(x.center_spacing)) / 100);
        if ($urandom_range(0, 9) == 0) x.offset_to_face = 31'($urandom());
        x.extent_first = 31'($urandom_range(1, 4) << $urandom_range(12, 17));
        x.extent_second = 31'($urandom_range(1, 4) << $urandom_range(12, 17));
        if ($urandom_range(0, 9) == 0) x.extent_first = 31'($urandom());
        if ($urandom_range(0, 9) == 0) x.extent_second = 31'($urandom());
        x.vel_here = rand_word();
        x.vel_next = rand_word();
        x.invdiag_here = rand_word();
        x.invdiag_next = rand_word();
        x.grad_here = rand_word();
        x.grad_next = rand_word();
        x.press_here = rand_word();
        x.press_next = rand_word();
        return x;
    endfunction

    // Input driver: pops the pending queue, holds payload while stalled; also drives out_stall.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall_seen) begin
                if (in_gap == 0 && face_queue.size() > 0) begin
                    in_data <= face_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid && in_gap == 0 && face_queue.size() > 0) begin
                in_valid <= 1'b1;
                in_data <= face_queue.pop_front();
            end
            if (in_gap > 0) in_gap <= in_gap - 1;
            else if (!calm && $urandom_range(0, 15) == 0) in_gap <= $urandom_range(1, 18);
            if (hold_output) out_stall <= 1'b1;
            else if (out_gap > 0) begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                out_stall <= 1'b1;
                out_gap <= $urandom_range(0, 17);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Sampled at the rising edge so the driver knows whether the last transaction went.
    always @(posedge i_clk) begin
        in_stall_seen <= !(in_valid && !in_stall);
        if (in_valid && !in_stall)
            expected_results.push_back(face_flux_of(in_data, density_q));
        if (cfg_valid && cfg_ready) density_q <= cfg_data;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h", out_data);
            end else begin
                ffmi_pkg::t_out want;
                want = expected_results.pop_front();
                if (want !== out_data) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: flux exp %h got %h, ",
                                  "link exp %h got %h, sat exp %b got %b"},
                                 want.face_flux, out_data.face_flux, want.link_coef,
                                 out_data.link_coef, want.saturated, out_data.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_density(logic [30:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (face_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic directed_faces();
        ffmi_pkg::t_in x;
        x = '0;
        x.center_spacing = 31'd65536;
        x.offset_to_face = 31'd32768;
        x.extent_first = 31'd65536;
        x.extent_second = 31'd65536;
        x.vel_here = 32'sd65536;
        x.vel_next = 32'sd131072;
        x.invdiag_here = 32'sd65536;
        x.invdiag_next = 32'sd65536;
        x.press_next = 32'sd65536;
        face_queue.push_back(x);
        x.offset_to_face = '0;
        face_queue.push_back(x);
        x.offset_to_face = 31'd131072;     // offset beyond spacing
        face_queue.push_back(x);
        x.center_spacing = 31'd1;          // tiny spacing, quotient overflow
        face_queue.push_back(x);
        x.center_spacing = 31'h7fffffff;
        x.offset_to_face = 31'h7fffffff;
        face_queue.push_back(x);
        x = '1;
        face_queue.push_back(x);
        x.vel_here = 32'h80000000; x.vel_next = 32'h80000000;
        x.invdiag_here = 32'h80000000; x.invdiag_next = 32'h80000000;
        x.grad_here = 32'h80000000; x.grad_next = 32'h80000000;
        x.press_here = 32'h7fffffff; x.press_next = 32'h80000000;
        face_queue.push_back(x);
        x = '0;
        x.center_spacing = 31'd65536;
        x.press_here = 32'sd5; x.press_next = 32'sd5;
        x.grad_here = -32'sd3; x.grad_next = 32'sd0;   // halving truncates toward zero
        face_queue.push_back(x);
        repeat (8) face_queue.push_back(random_face());
    endtask

    initial begin
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_faces();
        drain();
        write_density(31'd0);
        repeat (12) face_queue.push_back(random_face());
        drain();
        write_density(31'h7fffffff);
        repeat (12) face_queue.push_back(random_face());
        drain();
        write_density(31'd98304);

        // Hold the output long enough to fill the pipeline and stall the input.
        hold_output = 1'b1;
        repeat (120) face_queue.push_back(random_face());
        n = 0;
        while (n < 200) begin
            @(posedge i_clk);
            n++;
        end
        hold_output = 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_density(phase == 3 ? ffmi_pkg::DENSITY_RESET
                                     : 31'($urandom_range(1, 1 << 20)));
            if (phase == 3) calm = 1'b1;
            repeat (220) face_queue.push_back(random_face());
            drain();
        end

        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
